// ===== rtl/htc_pkg.sv =====
package htc_pkg;

    // Coordinate width of the input fields on the ports
    localparam int unsigned CoordBits = 16;

    typedef struct packed {
        logic signed [CoordBits-1:0] vec_m;
        logic signed [CoordBits-1:0] vec_n;
        logic signed [CoordBits-1:0] vec_m1;
        logic signed [CoordBits-1:0] vec_n1;
    } htc_in_t;

    typedef struct packed {
        logic [31:0] cell_area;
        logic [15:0] gcd_first;
        logic [15:0] gcd_second;
        logic [31:0] tile_width;
        logic [31:0] tile_width_alt;
        logic [30:0] row_shift;
        logic        degenerate;
    } htc_out_t;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } htc_div_stat_t;

endpackage

// ===== rtl/htc_divider.sv =====
module htc_divider import htc_pkg::*; #(
    parameter int unsigned DW = 33
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output logic [DW-1:0] remainder,
    output htc_div_stat_t stat
);

    localparam int unsigned CW = $clog2(DW);

    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    // One restoring step per cycle
    always_comb begin
        shifted   = {rem_reg, quo_reg[DW-1]};
        diff      = shifted - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(DW - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DW]) begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = shifted[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat      = '{busy: busy_reg, done: done_reg};

endmodule

// ===== rtl/halftone_cell_parameters.sv =====
// Halftone cell parameters: one word in, one word out, one item at a time.
// One shared divider does every divide: one per Euclid step of both gcds and two for
// the tile widths (none when either gcd is zero). When the shift walk runs, it takes
// one walk step at a time (up to |M1|/D + |N|/D steps), then one modulo divide.
// A new word is taken only after the last result is taken; s_ready is high only while idle.
// Reset (aresetn, synchronous, active low) returns to idle with no word pending.
module halftone_cell_parameters import htc_pkg::*; #(
    parameter int unsigned COORD_BITS = CoordBits
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  htc_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output htc_out_t m_data
);

    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned AW = 2 * CB;
    localparam int unsigned DW = 2 * CB + 1;
    localparam int unsigned HW = CB + 2;
    localparam int unsigned PW = HW + CB + 1;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MUL0 = 5'd1;
    localparam logic [4:0] S_MUL1 = 5'd2;
    localparam logic [4:0] S_AREA = 5'd3;
    localparam logic [4:0] S_G1   = 5'd4;
    localparam logic [4:0] S_G1W  = 5'd5;
    localparam logic [4:0] S_G2   = 5'd6;
    localparam logic [4:0] S_G2W  = 5'd7;
    localparam logic [4:0] S_CHK  = 5'd8;
    localparam logic [4:0] S_W0W  = 5'd9;
    localparam logic [4:0] S_W1   = 5'd10;
    localparam logic [4:0] S_W1W  = 5'd11;
    localparam logic [4:0] S_WALK = 5'd12;
    localparam logic [4:0] S_SH0  = 5'd13;
    localparam logic [4:0] S_SH1  = 5'd14;
    localparam logic [4:0] S_SHS  = 5'd15;
    localparam logic [4:0] S_MODS = 5'd16;
    localparam logic [4:0] S_MODW = 5'd17;
    localparam logic [4:0] S_FIN  = 5'd18;
    localparam logic [4:0] S_OUT  = 5'd19;

    logic [4:0]           state_reg, state_next;
    logic signed [CB-1:0] vm_reg, vm_next, vn_reg, vn_next;
    logic signed [CB-1:0] vm1_reg, vm1_next, vn1_reg, vn1_next;
    logic [CB-1:0]        m_mag, n_mag, m1_mag, n1_mag;
    logic [AW-1:0]        area_reg, area_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic [CB-1:0]        ga_reg, ga_next, gb_reg, gb_next;
    logic [CB-1:0]        d_reg, d_next, d1_reg, d1_next;
    logic [AW-1:0]        w_reg, w_next, w1_reg, w1_next, s_reg, s_next;
    logic signed [HW-1:0] h_reg, h_next, k_reg, k_next, dy_reg, dy_next;
    logic signed [PW-1:0] sh_reg, sh_next;
    logic signed [PW-1:0] sh_abs;
    logic signed [HW-1:0] d_ext;
    htc_out_t             out_reg, out_next;
    logic                 mv_reg, mv_next;

    logic signed [HW-1:0] mul_a;
    logic signed [CB:0]   mul_b;
    logic signed [PW-1:0] mul_p;

    logic                 div_start;
    logic [DW-1:0]        div_a, div_b, div_q, div_r;
    htc_div_stat_t        div_stat;

    htc_divider #(.DW(DW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .quotient  (div_q),
        .remainder (div_r),
        .stat      (div_stat)
    );

    // Magnitudes of the held coordinates
    assign m_mag  = vm_reg[CB-1]  ? CB'(-vm_reg)  : vm_reg;
    assign n_mag  = vn_reg[CB-1]  ? CB'(-vn_reg)  : vn_reg;
    assign m1_mag = vm1_reg[CB-1] ? CB'(-vm1_reg) : vm1_reg;
    assign n1_mag = vn1_reg[CB-1] ? CB'(-vn1_reg) : vn1_reg;
    assign d_ext  = $signed({2'b00, d_reg});
    assign sh_abs = sh_reg[PW-1] ? -sh_reg : sh_reg;

    // Shared multiplier, operands picked by state
    always_comb begin
        unique case (state_reg)
            S_MUL0: begin
                mul_a = $signed({2'b00, m_mag});
                mul_b = $signed({1'b0, m1_mag});
            end
            S_MUL1: begin
                mul_a = $signed({2'b00, n_mag});
                mul_b = $signed({1'b0, n1_mag});
            end
            S_SH0: begin
                mul_a = h_reg;
                mul_b = (CB + 1)'(vm_reg);
            end
            default: begin
                mul_a = k_reg;
                mul_b = (CB + 1)'(vn1_reg);
            end
        endcase
    end
    assign mul_p = PW'(mul_a * mul_b);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        vm_next    = vm_reg;
        vn_next    = vn_reg;
        vm1_next   = vm1_reg;
        vn1_next   = vn1_reg;
        area_next  = area_reg;
        prod_next  = prod_reg;
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        d_next     = d_reg;
        d1_next    = d1_reg;
        w_next     = w_reg;
        w1_next    = w1_reg;
        s_next     = s_reg;
        h_next     = h_reg;
        k_next     = k_reg;
        dy_next    = dy_reg;
        sh_next    = sh_reg;
        out_next   = out_reg;
        mv_next    = mv_reg;
        div_start  = 1'b0;
        div_a      = DW'(ga_reg);
        div_b      = DW'(gb_reg);
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    vm_next    = CB'(s_data.vec_m);
                    vn_next    = CB'(s_data.vec_n);
                    vm1_next   = CB'(s_data.vec_m1);
                    vn1_next   = CB'(s_data.vec_n1);
                    state_next = S_MUL0;
                end
            end
            S_MUL0: begin
                prod_next  = mul_p;
                state_next = S_MUL1;
            end
            S_MUL1: begin
                area_next  = AW'(prod_reg);
                prod_next  = mul_p;
                state_next = S_AREA;
            end
            S_AREA: begin
                area_next  = area_reg + AW'(prod_reg);
                ga_next    = m1_mag;
                gb_next    = n_mag;
                state_next = S_G1;
            end
            S_G1: begin
                if (gb_reg == '0) begin
                    d_next     = ga_reg;
                    ga_next    = m_mag;
                    gb_next    = n1_mag;
                    state_next = S_G2;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_G1W;
                end
            end
            S_G1W: begin
                if (div_stat.done) begin
                    ga_next    = gb_reg;
                    gb_next    = CB'(div_r);
                    state_next = S_G1;
                end
            end
            S_G2: begin
                if (gb_reg == '0) begin
                    d1_next    = ga_reg;
                    state_next = S_CHK;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_G2W;
                end
            end
            S_G2W: begin
                if (div_stat.done) begin
                    ga_next    = gb_reg;
                    gb_next    = CB'(div_r);
                    state_next = S_G2;
                end
            end
            S_CHK: begin
                if (d_reg == '0 || d1_reg == '0) begin
                    out_next            = '0;
                    out_next.degenerate = 1'b1;
                    mv_next             = 1'b1;
                    state_next          = S_OUT;
                end else begin
                    div_start  = 1'b1;
                    div_a      = DW'(area_reg);
                    div_b      = DW'(d_reg);
                    state_next = S_W0W;
                end
            end
            S_W0W: begin
                if (div_stat.done) begin
                    w_next     = AW'(div_q);
                    state_next = S_W1;
                end
            end
            S_W1: begin
                div_start  = 1'b1;
                div_a      = DW'(area_reg);
                div_b      = DW'(d1_reg);
                state_next = S_W1W;
            end
            S_W1W: begin
                if (div_stat.done) begin
                    w1_next = AW'(div_q);
                    h_next  = '0;
                    k_next  = '0;
                    dy_next = '0;
                    s_next  = '0;
                    if (vm1_reg != '0 && vn_reg != '0) begin
                        state_next = S_WALK;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            // One walk step per cycle until the offset hits D
            S_WALK: begin
                if (dy_reg == d_ext) begin
                    state_next = S_SH0;
                end else if (dy_reg > d_ext) begin
                    k_next  = vm1_reg[CB-1] ? k_reg - 1'b1 : k_reg + 1'b1;
                    dy_next = dy_reg - $signed({2'b00, m1_mag});
                end else begin
                    h_next  = vn_reg[CB-1] ? h_reg - 1'b1 : h_reg + 1'b1;
                    dy_next = dy_reg + $signed({2'b00, n_mag});
                end
            end
            S_SH0: begin
                prod_next  = mul_p;
                state_next = S_SH1;
            end
            S_SH1: begin
                sh_next    = prod_reg;
                prod_next  = mul_p;
                state_next = S_SHS;
            end
            S_SHS: begin
                sh_next    = sh_reg + prod_reg;
                state_next = S_MODS;
            end
            S_MODS: begin
                if (w_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    div_start  = 1'b1;
                    div_a      = DW'(sh_abs);
                    div_b      = DW'(w_reg);
                    state_next = S_MODW;
                end
            end
            // Non-negative remainder of -sh
            S_MODW: begin
                if (div_stat.done) begin
                    if (!sh_reg[PW-1] && div_r != '0) begin
                        s_next = w_reg - AW'(div_r);
                    end else begin
                        s_next = AW'(div_r);
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                out_next.cell_area      = 32'(area_reg);
                out_next.gcd_first      = 16'(d_reg);
                out_next.gcd_second     = 16'(d1_reg);
                out_next.tile_width     = 32'(w_reg);
                out_next.tile_width_alt = 32'(w1_reg);
                out_next.row_shift      = 31'(s_reg);
                out_next.degenerate     = 1'b0;
                mv_next                 = 1'b1;
                state_next              = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    mv_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        vm_reg   <= vm_next;
        vn_reg   <= vn_next;
        vm1_reg  <= vm1_next;
        vn1_reg  <= vn1_next;
        area_reg <= area_next;
        prod_reg <= prod_next;
        ga_reg   <= ga_next;
        gb_reg   <= gb_next;
        d_reg    <= d_next;
        d1_reg   <= d1_next;
        w_reg    <= w_next;
        w1_reg   <= w1_next;
        s_reg    <= s_next;
        h_reg    <= h_next;
        k_reg    <= k_next;
        dy_reg   <= dy_next;
        sh_reg   <= sh_next;
        out_reg  <= out_next;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/htc_checker.sv =====
module htc_checker import htc_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input htc_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input htc_out_t m_data
);

    // Offered input word holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while stalled");

    // Pending result word holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // No new word is taken while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while result pending");

    // Degenerate results carry zero area, gcds, tile width and row shift
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> m_data.cell_area == '0 &&
        m_data.gcd_first == '0 && m_data.gcd_second == '0 &&
        m_data.tile_width == '0 && m_data.row_shift == '0)
        else $error("degenerate word with nonzero fields");

    // An accepted input is not followed at once by a valid result
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result too soon after input");

endmodule

bind halftone_cell_parameters htc_checker u_htc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import htc_pkg::*;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    htc_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    htc_out_t m_data;

    halftone_cell_parameters i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    htc_in_t  pending_words[$];
    htc_out_t cell_results[$];
    int       err_count = 0;
    int       sent_count = 0;
    int       total_words = 0;
    int       hold_stretch = 0;   // forced receiver hold-off, in cycles
    bit       drain_req = 1'b0;   // sender waits for results to drain
    bit       fill_done = 1'b0;

    function automatic longint unsigned abs_of(logic signed [15:0] v);
        longint sv;
        sv = v;
        return sv < 0 ? longint'(-sv) : longint'(sv);
    endfunction

    function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Predict one output word from one input word
    function automatic htc_out_t cell_params(htc_in_t w);
        htc_out_t r;
        longint unsigned m, n, m1, n1, area, d, d1, wd, wd1;
        longint h, k, dy, sd, sh, rem, vm, vn, vm1, vn1;
        r = '0;
        vm = w.vec_m; vn = w.vec_n; vm1 = w.vec_m1; vn1 = w.vec_n1;
        m = abs_of(w.vec_m); n = abs_of(w.vec_n);
        m1 = abs_of(w.vec_m1); n1 = abs_of(w.vec_n1);
        area = m * m1 + n * n1;
        d = gcd_of(m1, n);
        d1 = gcd_of(m, n1);
        if (d == 0 || d1 == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        wd = area / d;
        wd1 = area / d1;
        // offset walk, only when both M1 and N are nonzero
        if (vm1 != 0 && vn != 0) begin
            h = 0; k = 0; dy = 0; sd = longint'(d);
            while (dy != sd) begin
                if (dy > sd) begin
                    k += (vm1 > 0) ? 1 : -1;
                    dy -= longint'(m1);
                end else begin
                    h += (vn > 0) ? 1 : -1;
                    dy += longint'(n);
                end
            end
            sh = h * vm + k * vn1;
            if (wd != 0) begin
                rem = (-sh) % longint'(wd);
                if (rem < 0) rem += longint'(wd);
                r.row_shift = rem[30:0];
            end
        end
        r.cell_area = area[31:0];
        r.gcd_first = d[15:0];
        r.gcd_second = d1[15:0];
        r.tile_width = wd[31:0];
        r.tile_width_alt = wd1[31:0];
        return r;
    endfunction

    function automatic htc_in_t mk_word(int a, int b, int c, int e);
        htc_in_t w;
        w.vec_m = a[15:0]; w.vec_n = b[15:0]; w.vec_m1 = c[15:0]; w.vec_n1 = e[15:0];
        return w;
    endfunction

    // Mostly small vectors keep the walk short; some full-range ones
    function automatic logic [15:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 16'($signed($urandom_range(0, 64)) - 32);
        if (sel < 8) return 16'($signed($urandom_range(0, 1024)) - 512);
        return 16'($urandom);
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    initial begin
        int ext[6];
        htc_in_t w;
        ext = '{0, 1, -1, 32767, -32768, 3};
        // directed: extremes, zero gcd, M1 or N zero, mixed signs
        pending_words.push_back(mk_word(0, 0, 0, 0));
        pending_words.push_back(mk_word(5, 0, 0, 7));
        pending_words.push_back(mk_word(0, 3, 4, 0));
        pending_words.push_back(mk_word(4, 0, 6, 2));
        pending_words.push_back(mk_word(3, 5, 0, 7));
        pending_words.push_back(mk_word(-32768, -32768, -32768, -32768));
        pending_words.push_back(mk_word(32767, 32767, 32767, 32767));
        pending_words.push_back(mk_word(32767, -32768, 32767, -32768));
        pending_words.push_back(mk_word(-32768, 1, -1, 32767));
        pending_words.push_back(mk_word(3, 4, -5, 6));
        pending_words.push_back(mk_word(-7, -3, 2, -9));
        pending_words.push_back(mk_word(12, 8, 6, -18));
        pending_words.push_back(mk_word(-1, 1, 1, -1));
        pending_words.push_back(mk_word(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        pending_words.push_back(mk_word(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        for (int i = 0; i < 6; i++) begin
            pending_words.push_back(mk_word(ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6],
                                            ext[(i + 3) % 6]));
        end
        for (int i = 0; i < 120; i++) begin
            w.vec_m = rand_coord(); w.vec_n = rand_coord();
            w.vec_m1 = rand_coord(); w.vec_n1 = rand_coord();
            pending_words.push_back(w);
        end
        total_words = pending_words.size();
        fill_done = 1'b1;
    end

    // reset, then pressure phases keyed to progress
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        wait (sent_count >= 30);
        @(posedge aclk);
        hold_stretch <= 400;
        wait (sent_count >= 80);
        @(posedge aclk);
        drain_req <= 1'b1;
        @(posedge aclk);
        while (cell_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
        drain_req <= 1'b0;
    end

    // driver
    int src_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && s_ready) begin
            cell_results.push_back(cell_params(s_data));
            sent_count <= sent_count + 1;
            src_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (src_gap == 0 && $urandom_range(0, 1) != 0 && pending_words.size() != 0
                    && !drain_req) begin
                s_data <= pending_words.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end else if (!s_valid) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
            end else if (fill_done && pending_words.size() != 0 && !drain_req) begin
                s_data <= pending_words.pop_front();
                s_valid <= 1'b1;
            end
        end
    end

    // monitor and checker
    int snk_gap = 0;
    int hold_cnt = 0;
    bit hold_seen = 1'b0;
    always @(posedge aclk) begin
        htc_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (cell_results.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = cell_results.pop_front();
                    if (m_data.cell_area != want.cell_area)
                        report_mismatch("cell_area", m_data.cell_area, want.cell_area);
                    if (m_data.gcd_first != want.gcd_first)
                        report_mismatch("gcd_first", m_data.gcd_first, want.gcd_first);
                    if (m_data.gcd_second != want.gcd_second)
                        report_mismatch("gcd_second", m_data.gcd_second, want.gcd_second);
                    if (m_data.tile_width != want.tile_width)
                        report_mismatch("tile_width", m_data.tile_width, want.tile_width);
                    if (m_data.tile_width_alt != want.tile_width_alt)
                        report_mismatch("tile_width_alt", m_data.tile_width_alt,
                                        want.tile_width_alt);
                    if (m_data.row_shift != want.row_shift)
                        report_mismatch("row_shift", m_data.row_shift, want.row_shift);
                    if (m_data.degenerate != want.degenerate)
                        report_mismatch("degenerate", m_data.degenerate, want.degenerate);
                end
            end
            // long hold-off once, then random stalls per word
            if (hold_stretch != 0 && !hold_seen) begin
                hold_seen <= 1'b1;
                hold_cnt <= hold_stretch;
                m_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready <= (hold_cnt == 1);
            end else if (m_valid && m_ready) begin
                snk_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
                m_ready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog and end of run
    int idle_cycles = 0;
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= 2000000) begin
                $display("tb_top: done, errors");
                $finish;
            end
            if (fill_done && aresetn && pending_words.size() == 0 && !s_valid
                    && cell_results.size() == 0 && sent_count == total_words) begin
                repeat (200) @(posedge aclk);
                if (err_count == 0 && cell_results.size() == 0)
                    $display("tb_top: done, clean");
                else
                    $display("tb_top: done, errors");
                $finish;
            end
        end
    end

endmodule

// ===== halftone_cell_parameters.f =====
rtl/htc_pkg.sv
rtl/htc_divider.sv
rtl/halftone_cell_parameters.sv
rtl/htc_checker.sv
sim/tb_top.sv
